// File: rtl/core/ikc_pkg.sv
`timescale 1ns / 1ps

package ikc_pkg;

   localparam int MAX_KERNEL     = 5;
   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 4096;
   localparam int COEF_FRAC_BITS = 8;
   localparam int RING_ROWS      = MAX_KERNEL + 1;
   localparam int NUM_TAPS       = MAX_KERNEL * MAX_KERNEL;
   localparam int NUM_CH         = 4;

   localparam int COL_W  = 10;
   localparam int ROW_W  = 12;
   localparam int RING_W = 3;
   localparam int K_W    = 3;
   localparam int TAP_W  = 5;
   localparam int ACC_W  = 32;
   localparam int PIX_W  = 32;
   localparam int COEF_W = 16;
   localparam int MEM_AW = RING_W + COL_W;

   localparam logic [1:0] OP_COEF  = 2'd0;
   localparam logic [1:0] OP_PIXEL = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_KERNEL = 2'd2;
   localparam logic [1:0] REG_BORDER = 2'd3;

   typedef struct packed {
      logic                     vld;
      logic                     clr;
      logic                     fin;
      logic [PIX_W-1:0]         px;
      logic signed [COEF_W-1:0] coef;
   } beat_type;

   function automatic logic [7:0] sat_channel(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] sh;
      sh = acc >>> COEF_FRAC_BITS;
      if (acc < 0) begin
         return 8'd0;
      end else if (sh > ACC_W'(255)) begin
         return 8'hFF;
      end else begin
         return sh[7:0];
      end
   endfunction

endpackage

// File: rtl/core/image_kernel_convolution_core.sv
`timescale 1ns / 1ps

// RGBA raster convolution with a square kernel of up to 5x5 signed Q8.8 taps.
// Coefficient, flush and non-producing pixel beats keep the block idle. A
// producing beat runs the centre, tap (none for k of 0), finish, wait and
// hold states: the single read port of the six-row line store delivers one
// tap per cycle, and the tap stream then passes a chain of four cells, one per
// channel, before the result is loaded into the output register. The block
// accepts the next beat as soon as that register is loaded, even if the
// result is still stalled. Writing width, height or kernel size restarts the
// frame. Line store contents are not cleared at reset; no window reads an
// entry before the current frame has written it.
module image_kernel_convolution_core import ikc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [7:0]         req_pix_red,
   input  logic [7:0]         req_pix_green,
   input  logic [7:0]         req_pix_blue,
   input  logic [7:0]         req_pix_alpha,
   input  logic [4:0]         req_coef_index,
   input  logic signed [15:0] req_coef_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [9:0]         rsp_out_col,
   output logic [11:0]        rsp_out_row,
   output logic [7:0]         rsp_res_red,
   output logic [7:0]         rsp_res_green,
   output logic [7:0]         rsp_res_blue,
   output logic [7:0]         rsp_res_alpha,
   output logic               rsp_frame_last,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CENTRE = 6'b000010,
      ST_TAPS   = 6'b000100,
      ST_FIN    = 6'b001000,
      ST_WAIT   = 6'b010000,
      ST_HOLD   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // geometry
   logic [COL_W-1:0] w_m1_ff;
   logic [ROW_W-1:0] h_m1_ff;
   logic [K_W-1:0]   k_ff, half_ff, ahead_ff;
   logic [PIX_W-1:0] border_ff;
   logic signed [COEF_W-1:0] tap_ff [NUM_TAPS];

   // frame position
   logic [COL_W-1:0]  in_col_ff, emit_col_ff;
   logic [ROW_W-1:0]  in_row_ff, emit_row_ff;
   logic [RING_W-1:0] in_ring_ff, emit_ring_ff;
   logic              frame_done_ff;

   // captured result position
   logic [COL_W-1:0]  cx_ff;
   logic [ROW_W-1:0]  cy_ff;
   logic [RING_W-1:0] cr_ff;
   logic              last_ff;

   logic [K_W-1:0] ti_ff, tj_ff;

   logic [PIX_W-1:0] mem [RING_ROWS*MAX_WIDTH];
   logic [PIX_W-1:0] rd_ff, centre_ff;
   logic [MEM_AW-1:0] rd_addr;

   logic                     s1_vld_ff, s1_clr_ff, s1_fin_ff, s1_inf_ff;
   logic signed [COEF_W-1:0] s1_coef_ff;

   logic                 rsp_valid_ff;
   logic [COL_W-1:0]     rsp_col_ff;
   logic [ROW_W-1:0]     rsp_row_ff;
   logic [7:0]           rsp_ch_ff [NUM_CH];
   logic                 rsp_last_ff;

   beat_type                beat [NUM_CH+1];
   logic signed [ACC_W-1:0] acc  [NUM_CH];

   logic acc_req, op_coef, op_pix, op_flush;
   logic pix_last, pix_store, go_emit, emit_cond, emit_last;
   logic [ROW_W:0]   nr;
   logic [COL_W:0]   nc;
   logic csr_restart, rsp_free, load_rsp, tap_last;

   logic [COL_W:0]    sxp;
   logic [ROW_W:0]    syp;
   logic [RING_W:0]   rr;
   logic [RING_W-1:0] tap_ring;
   logic              tap_inf;
   logic [TAP_W-1:0]  tidx;

   logic [10:0] cw;
   logic [12:0] chh;
   logic [K_W-1:0] ck;

   assign req_stall = (state_ff != ST_IDLE);
   assign acc_req   = req_valid && !req_stall;
   assign op_coef   = (req_opcode == OP_COEF);
   assign op_pix    = (req_opcode == OP_PIXEL);
   assign op_flush  = (req_opcode == OP_FLUSH);

   always_comb begin
      pix_last = (in_col_ff == w_m1_ff) && (in_row_ff == h_m1_ff);
      nr = {1'b0, emit_row_ff} + (ROW_W+1)'(ahead_ff);
      if (nr > {1'b0, h_m1_ff}) nr = {1'b0, h_m1_ff};
      nc = {1'b0, emit_col_ff} + (COL_W+1)'(ahead_ff);
      if (nc > {1'b0, w_m1_ff}) nc = {1'b0, w_m1_ff};
      emit_cond = (nr < {1'b0, in_row_ff}) ||
                  ((nr == {1'b0, in_row_ff}) && (nc <= {1'b0, in_col_ff}));
      pix_store = acc_req && op_pix && !frame_done_ff;
      go_emit   = acc_req && ((op_flush && frame_done_ff) ||
                  (op_pix && (frame_done_ff || pix_last || emit_cond)));
      emit_last = (emit_col_ff == w_m1_ff) && (emit_row_ff == h_m1_ff);
      csr_restart = csr_we && (csr_index != REG_BORDER);
   end

   // clamp register writes into the supported range
   always_comb begin
      cw  = csr_wdata[10:0];
      chh = csr_wdata[12:0];
      ck  = csr_wdata[2:0];
      if (ck > K_W'(MAX_KERNEL)) ck = K_W'(MAX_KERNEL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_m1_ff   <= COL_W'(MAX_WIDTH - 1);
         h_m1_ff   <= '0;
         k_ff      <= '0;
         half_ff   <= '0;
         ahead_ff  <= '0;
         border_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WIDTH: begin
               if (cw == '0) w_m1_ff <= '0;
               else if (cw > 11'(MAX_WIDTH)) w_m1_ff <= COL_W'(MAX_WIDTH - 1);
               else w_m1_ff <= COL_W'(cw - 11'd1);
            end
            REG_HEIGHT: begin
               if (chh == '0) h_m1_ff <= '0;
               else if (chh > 13'(MAX_HEIGHT)) h_m1_ff <= ROW_W'(MAX_HEIGHT - 1);
               else h_m1_ff <= ROW_W'(chh - 13'd1);
            end
            REG_KERNEL: begin
               k_ff     <= ck;
               half_ff  <= ck >> 1;
               ahead_ff <= (ck == '0) ? '0 : K_W'(ck - K_W'(1) - (ck >> 1));
            end
            REG_BORDER: begin
               border_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_TAPS; t++) tap_ff[t] <= '0;
      end else if (acc_req && op_coef && (req_coef_index < TAP_W'(NUM_TAPS))) begin
         tap_ff[req_coef_index] <= req_coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_restart) begin
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         in_ring_ff    <= '0;
         emit_col_ff   <= '0;
         emit_row_ff   <= '0;
         emit_ring_ff  <= '0;
         frame_done_ff <= 1'b0;
      end else if (go_emit && emit_last) begin
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         in_ring_ff    <= '0;
         emit_col_ff   <= '0;
         emit_row_ff   <= '0;
         emit_ring_ff  <= '0;
         frame_done_ff <= 1'b0;
      end else begin
         if (pix_store) begin
            if (pix_last) begin
               frame_done_ff <= 1'b1;
            end else if (in_col_ff == w_m1_ff) begin
               in_col_ff  <= '0;
               in_row_ff  <= in_row_ff + ROW_W'(1);
               in_ring_ff <= (in_ring_ff == RING_W'(RING_ROWS - 1)) ? '0 :
                             in_ring_ff + RING_W'(1);
            end else begin
               in_col_ff <= in_col_ff + COL_W'(1);
            end
         end
         if (go_emit) begin
            if (emit_col_ff == w_m1_ff) begin
               emit_col_ff  <= '0;
               emit_row_ff  <= emit_row_ff + ROW_W'(1);
               emit_ring_ff <= (emit_ring_ff == RING_W'(RING_ROWS - 1)) ? '0 :
                               emit_ring_ff + RING_W'(1);
            end else begin
               emit_col_ff <= emit_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go_emit) begin
         cx_ff   <= emit_col_ff;
         cy_ff   <= emit_row_ff;
         cr_ff   <= emit_ring_ff;
         last_ff <= emit_last;
      end
   end

   // tap address: column offset ti, row offset tj around the captured centre
   always_comb begin
      sxp     = {1'b0, cx_ff} + (COL_W+1)'(ti_ff);
      syp     = {1'b0, cy_ff} + (ROW_W+1)'(tj_ff);
      tap_inf = (sxp >= (COL_W+1)'(half_ff)) &&
                ((sxp - (COL_W+1)'(half_ff)) <= {1'b0, w_m1_ff}) &&
                (syp >= (ROW_W+1)'(half_ff)) &&
                ((syp - (ROW_W+1)'(half_ff)) <= {1'b0, h_m1_ff});
      rr = (RING_W+1)'(cr_ff) + (RING_W+1)'(tj_ff) + (RING_W+1)'(RING_ROWS) -
           (RING_W+1)'(half_ff);
      if (rr >= (RING_W+1)'(2 * RING_ROWS)) rr = rr - (RING_W+1)'(2 * RING_ROWS);
      else if (rr >= (RING_W+1)'(RING_ROWS)) rr = rr - (RING_W+1)'(RING_ROWS);
      tap_ring = rr[RING_W-1:0];
      tidx     = TAP_W'(ti_ff * MAX_KERNEL) + TAP_W'(tj_ff);
      tap_last = (ti_ff == k_ff - K_W'(1)) && (tj_ff == k_ff - K_W'(1));
      if (state_ff == ST_CENTRE) begin
         rd_addr = {cr_ff, cx_ff};
      end else begin
         rd_addr = {tap_ring, COL_W'(sxp - (COL_W+1)'(half_ff))};
      end
   end

   always_ff @(posedge clock) begin
      if (pix_store) begin
         mem[{in_ring_ff, in_col_ff}] <= {req_pix_red, req_pix_green,
                                          req_pix_blue, req_pix_alpha};
      end
      rd_ff <= mem[rd_addr];
      if (s1_clr_ff) centre_ff <= rd_ff;
   end

   always_ff @(posedge clock) begin
      s1_coef_ff <= tap_ff[tidx];
      s1_inf_ff  <= tap_inf;
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s1_clr_ff <= 1'b0;
         s1_fin_ff <= 1'b0;
      end else begin
         s1_vld_ff <= (state_ff == ST_TAPS);
         s1_clr_ff <= (state_ff == ST_CENTRE);
         s1_fin_ff <= (state_ff == ST_FIN);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CENTRE) begin
         ti_ff <= '0;
         tj_ff <= '0;
      end else if (state_ff == ST_TAPS) begin
         if (tj_ff == k_ff - K_W'(1)) begin
            tj_ff <= '0;
            ti_ff <= ti_ff + K_W'(1);
         end else begin
            tj_ff <= tj_ff + K_W'(1);
         end
      end
   end

   // outside the frame: positive taps see the border colour, negative the centre
   always_comb begin
      beat[0].vld  = s1_vld_ff;
      beat[0].clr  = s1_clr_ff;
      beat[0].fin  = s1_fin_ff;
      beat[0].coef = s1_coef_ff;
      if (s1_inf_ff) beat[0].px = rd_ff;
      else if (s1_coef_ff > 0) beat[0].px = border_ff;
      else beat[0].px = centre_ff;
   end

   for (genvar c = 0; c < NUM_CH; c++) begin : g_cell
      ikc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .beat_in  (beat[c]),
         .beat_out (beat[c+1]),
         .acc      (acc[c])
      );
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign load_rsp = (state_ff == ST_HOLD) && rsp_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (go_emit) state_in = ST_CENTRE;
         ST_CENTRE: state_in = (k_ff == '0) ? ST_FIN : ST_TAPS;
         ST_TAPS:   if (tap_last) state_in = ST_FIN;
         ST_FIN:    state_in = ST_WAIT;
         ST_WAIT:   if (beat[NUM_CH].fin) state_in = ST_HOLD;
         ST_HOLD:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_col_ff  <= cx_ff;
         rsp_row_ff  <= cy_ff;
         rsp_last_ff <= last_ff;
         for (int c = 0; c < NUM_CH; c++) rsp_ch_ff[c] <= sat_channel(acc[c]);
      end
      if (reset) rsp_valid_ff <= 1'b0;
      else if (load_rsp) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_res_red    = rsp_ch_ff[0];
   assign rsp_res_green  = rsp_ch_ff[1];
   assign rsp_res_blue   = rsp_ch_ff[2];
   assign rsp_res_alpha  = rsp_ch_ff[3];
   assign rsp_frame_last = rsp_last_ff;

`ifndef SYNTH
   a_fin_in_wait: assert property (@(posedge clock) disable iff (reset)
      beat[NUM_CH].fin |-> (state_ff == ST_WAIT))
      else $error("chain finished outside wait");

   a_done_pos: assert property (@(posedge clock) disable iff (reset)
      frame_done_ff |-> (in_col_ff == w_m1_ff) && (in_row_ff == h_m1_ff))
      else $error("frame done away from last pixel");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_HOLD))
      else $error("result loaded outside hold");
`endif

endmodule

// File: rtl/core/ikc_cell.sv
`timescale 1ns / 1ps

module ikc_cell import ikc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  beat_type                 beat_in,
   output beat_type                 beat_out,
   output logic signed [ACC_W-1:0]  acc
);

   beat_type                beat_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [24:0]      prod;

   // this cell works on the top byte, then shifts the next channel up for its neighbor
   always_comb begin
      prod   = $signed({1'b0, beat_in.px[PIX_W-1 -: 8]}) * beat_in.coef;
      acc_in = acc_ff;
      if (beat_in.clr) begin
         acc_in = '0;
      end else if (beat_in.vld) begin
         acc_in = acc_ff + ACC_W'(prod);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      beat_ff.px   <= beat_in.px << 8;
      beat_ff.coef <= beat_in.coef;
      if (reset) begin
         beat_ff.vld <= 1'b0;
         beat_ff.clr <= 1'b0;
         beat_ff.fin <= 1'b0;
      end else begin
         beat_ff.vld <= beat_in.vld;
         beat_ff.clr <= beat_in.clr;
         beat_ff.fin <= beat_in.fin;
      end
   end

   assign beat_out = beat_ff;
   assign acc      = acc_ff;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ikc_pkg::*;

   typedef struct {
      logic [1:0]         op;
      logic [7:0]         red, green, blue, alpha;
      logic [4:0]         idx;
      logic signed [15:0] coef;
   } tb_beat_type;

   typedef struct packed {
      logic [9:0]  col;
      logic [11:0] row;
      logic [7:0]  red, green, blue, alpha;
      logic        last;
   } filtered_px_type;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_WAIT  = 60;
   localparam int ITEM_TARGET = 500;

   // opcode with no function, the block accepts it and does nothing
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode = OP_PIXEL;
   logic [7:0]         req_pix_red = '0, req_pix_green = '0;
   logic [7:0]         req_pix_blue = '0, req_pix_alpha = '0;
   logic [4:0]         req_coef_index = '0;
   logic signed [15:0] req_coef_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [9:0]         rsp_out_col;
   logic [11:0]        rsp_out_row;
   logic [7:0]         rsp_res_red, rsp_res_green, rsp_res_blue, rsp_res_alpha;
   logic               rsp_frame_last;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = REG_WIDTH;
   logic [31:0]        csr_wdata = '0;

   image_kernel_convolution_core dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mirror of the block state
   logic [31:0]        line_mem [RING_ROWS][MAX_WIDTH];
   logic signed [15:0] taps [NUM_TAPS];
   int unsigned        cfg_w = 1024, cfg_h = 1, cfg_k = 0;
   logic [31:0]        cfg_border = '0;
   int unsigned        in_c = 0, in_r = 0, em_c = 0, em_r = 0;
   bit                 frame_full = 0;

   tb_beat_type     beat_q[$];
   filtered_px_type pixel_q[$];
   tb_beat_type     cur;
   int              send_idle_pct = 0, stall_pct = 0;
   int              fail_count = 0;
   int              cycles = 0;
   int              beats_sent = 0;

   function automatic int unsigned eff_w();
      if (cfg_w == 0) return 1;
      return (cfg_w > MAX_WIDTH) ? MAX_WIDTH : cfg_w;
   endfunction

   function automatic int unsigned eff_h();
      if (cfg_h == 0) return 1;
      return (cfg_h > MAX_HEIGHT) ? MAX_HEIGHT : cfg_h;
   endfunction

   function automatic int unsigned eff_k();
      return (cfg_k > MAX_KERNEL) ? MAX_KERNEL : cfg_k;
   endfunction

   function automatic void restart_frame();
      in_c = 0; in_r = 0; em_c = 0; em_r = 0;
      frame_full = 0;
   endfunction

   function automatic logic [7:0] clip_channel(longint acc);
      longint v;
      if (acc < 0) return 8'd0;
      v = acc >>> COEF_FRAC_BITS;
      return (v > 255) ? 8'hFF : v[7:0];
   endfunction

   function automatic void apply_csr(logic [1:0] idx, logic [31:0] val);
      case (idx)
         REG_WIDTH: begin
            cfg_w = 32'(val[10:0]); restart_frame();
         end
         REG_HEIGHT: begin
            cfg_h = 32'(val[12:0]); restart_frame();
         end
         REG_KERNEL: begin
            cfg_k = 32'(val[2:0]); restart_frame();
         end
         default: cfg_border = val;
      endcase
   endfunction

   function automatic void emit_filtered();
      int unsigned w, h, k, cx, cy;
      int          half, sx, sy, c;
      logic [31:0] centre, px;
      longint      acc [4];
      filtered_px_type res;
      w = eff_w(); h = eff_h(); k = eff_k();
      half = k / 2;
      cx = em_c; cy = em_r;
      centre = line_mem[cy % RING_ROWS][cx % MAX_WIDTH];
      for (int ch = 0; ch < 4; ch++) acc[ch] = 0;
      for (int i = 0; i < k; i++) begin
         for (int j = 0; j < k; j++) begin
            c = taps[i * MAX_KERNEL + j];
            if (c == 0) continue;
            sx = int'(cx) + i - half;
            sy = int'(cy) + j - half;
            if (sx >= 0 && sy >= 0 && sx < int'(w) && sy < int'(h))
               px = line_mem[sy % RING_ROWS][sx % MAX_WIDTH];
            else
               px = (c > 0) ? cfg_border : centre;
            for (int ch = 0; ch < 4; ch++)
               acc[ch] += longint'((px >> (24 - 8 * ch)) & 32'hFF) * c;
         end
      end
      res.col   = cx[9:0];
      res.row   = cy[11:0];
      res.red   = clip_channel(acc[0]);
      res.green = clip_channel(acc[1]);
      res.blue  = clip_channel(acc[2]);
      res.alpha = clip_channel(acc[3]);
      res.last  = (cx == w - 1 && cy == h - 1);
      pixel_q.push_back(res);
      if (res.last) restart_frame();
      else if (cx + 1 >= w) begin
         em_c = 0; em_r = cy + 1;
      end else em_c = cx + 1;
   endfunction

   function automatic void predict_beat(tb_beat_type b);
      int unsigned w, h, k, ahead, nr, nc, pc, pr;
      w = eff_w(); h = eff_h(); k = eff_k();
      case (b.op)
         OP_COEF: begin
            if (b.idx < NUM_TAPS) taps[b.idx] = b.coef;
         end
         OP_FLUSH: begin
            if (frame_full) emit_filtered();
         end
         OP_PIXEL: begin
            if (frame_full) emit_filtered();
            else begin
               pc = in_c; pr = in_r;
               ahead = (k != 0) ? k - 1 - k / 2 : 0;
               line_mem[pr % RING_ROWS][pc % MAX_WIDTH] = {b.red, b.green, b.blue, b.alpha};
               if (pc == w - 1 && pr == h - 1) frame_full = 1;
               else if (pc + 1 >= w) begin
                  in_c = 0; in_r = pr + 1;
               end else in_c = pc + 1;
               if (frame_full) emit_filtered();
               else begin
                  nr = em_r + ahead; if (nr > h - 1) nr = h - 1;
                  nc = em_c + ahead; if (nc > w - 1) nc = w - 1;
                  if (nr < pr || (nr == pr && nc <= pc)) emit_filtered();
               end
            end
         end
         default: ;
      endcase
   endfunction

   // request side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_beat(cur);
         if (!req_valid || !req_stall) begin
            if (beat_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur = beat_q.pop_front();
               req_valid      <= 1'b1;
               req_opcode     <= cur.op;
               req_pix_red    <= cur.red;
               req_pix_green  <= cur.green;
               req_pix_blue   <= cur.blue;
               req_pix_alpha  <= cur.alpha;
               req_coef_index <= cur.idx;
               req_coef_value <= cur.coef;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side
   always @(posedge clock) begin
      filtered_px_type got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_col, rsp_out_row, rsp_res_red, rsp_res_green,
                    rsp_res_blue, rsp_res_alpha, rsp_frame_last};
            if (pixel_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected beat: col %0d row %0d rgba %h %h %h %h last %b",
                           got.col, got.row, got.red, got.green, got.blue, got.alpha,
                           got.last);
            end else begin
               want = pixel_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected col %0d row %0d rgba %h %h %h %h last %b, got col %0d row %0d rgba %h %h %h %h last %b",
                              want.col, want.row, want.red, want.green, want.blue,
                              want.alpha, want.last, got.col, got.row, got.red,
                              got.green, got.blue, got.alpha, got.last);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic add_beat(logic [1:0] op, logic [4:0] idx, logic signed [15:0] coef,
                           logic [31:0] rgba);
      tb_beat_type b;
      b.op = op; b.idx = idx; b.coef = coef;
      {b.red, b.green, b.blue, b.alpha} = rgba;
      beat_q.push_back(b);
      beats_sent++;
   endtask

   task automatic add_pixel();
      add_beat(OP_PIXEL, 5'($urandom_range(31)), 16'($urandom), $urandom);
   endtask

   task automatic add_coef();
      logic signed [15:0] v;
      case ($urandom_range(5))
         0: v = '0;
         1: v = 16'($urandom);
         default: v = 16'($urandom_range(1200) - 400);
      endcase
      add_beat(OP_COEF,
               5'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(24)),
               v, $urandom);
   endtask

   task automatic settle();
      while (beat_q.size() != 0 || req_valid) @(posedge clock);
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      apply_csr(idx, val);
   endtask

   task automatic set_geometry(int unsigned w, int unsigned h, int unsigned k,
                               logic [31:0] border);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
      csr_write(REG_KERNEL, k);
      csr_write(REG_BORDER, border);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // whole frame then drain; oversized frames only get a partial stream
   task automatic stream_frame();
      int unsigned w, h, k, ahead, total, mid_pixels;
      w = eff_w(); h = eff_h(); k = eff_k();
      ahead = (k != 0) ? k - 1 - k / 2 : 0;
      total = w * h;
      if (total > 60) begin
         repeat (20 + $urandom_range(20)) add_pixel();
         return;
      end
      if ($urandom_range(3) == 0) add_beat(OP_FLUSH, 5'd0, 16'sd0, $urandom);
      for (int n = 0; n < total; n++) begin
         if ($urandom_range(11) == 0) add_coef();
         if ($urandom_range(29) == 0)
            add_beat(OP_UNUSED, 5'($urandom), 16'($urandom), $urandom);
         add_pixel();
      end
      mid_pixels = (h > ahead && w > ahead) ? ahead : 0;
      for (int n = 0; n < 2 * w + 4; n++) begin
         if (n < mid_pixels && $urandom_range(2) == 0) add_pixel();
         else add_beat(OP_FLUSH, 5'($urandom), 16'($urandom), $urandom);
      end
   endtask

   initial begin
      int phase;
      int unsigned w, h, k;
      for (int r = 0; r < RING_ROWS; r++)
         for (int c = 0; c < MAX_WIDTH; c++) line_mem[r][c] = '0;
      for (int t = 0; t < NUM_TAPS; t++) taps[t] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: zero kernel gives zero output at once
      add_beat(OP_PIXEL, 5'd0, 16'sd0, 32'hFFFFFFFF);
      add_beat(OP_PIXEL, 5'd0, 16'sd0, 32'h00000000);
      settle();

      set_geometry(3, 2, 3, 32'hFFFFFFFF);
      add_beat(OP_FLUSH, 5'd0, 16'sd0, '0);
      add_beat(OP_COEF, 5'd0, -16'sd32768, '0);
      add_beat(OP_COEF, 5'd2, 16'sd32767, '0);
      add_beat(OP_COEF, 5'd12, 16'sd256, '0);
      add_beat(OP_COEF, 5'd10, -16'sd128, '0);
      add_beat(OP_COEF, 5'd25, 16'sd300, '0);
      add_beat(OP_COEF, 5'd31, -16'sd1, '0);
      add_beat(OP_UNUSED, 5'd31, -16'sd1, 32'hFFFFFFFF);
      add_beat(OP_PIXEL, 5'd0, 16'sd0, 32'hFFFFFFFF);
      add_beat(OP_PIXEL, 5'd0, 16'sd0, 32'h00000000);
      repeat (4) add_pixel();
      add_beat(OP_PIXEL, 5'd0, 16'sd0, 32'h12345678);
      repeat (4) add_beat(OP_FLUSH, 5'd0, 16'sd0, '0);
      add_beat(OP_FLUSH, 5'd0, 16'sd0, '0);
      settle();

      // out-of-range geometry
      set_geometry(0, 0, 7, 32'h80FF0001);
      add_beat(OP_COEF, 5'd0, 16'sd256, '0);
      repeat (3) add_pixel();
      settle();
      set_geometry(2047, 8191, 6, $urandom);
      repeat (2) add_coef();
      repeat (30) add_pixel();
      settle();
      set_geometry(1, 4096, 5, $urandom);
      repeat (25) add_pixel();
      settle();

      phase = 0;
      while (beats_sent < ITEM_TARGET) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 88; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 88; end
            default: begin send_idle_pct = 14; stall_pct = 14; end
         endcase
         if ($urandom_range(9) == 0) begin
            w = ($urandom_range(1)) ? 1024 : 2047;
            h = $urandom_range(8191);
         end else begin
            w = $urandom_range(8);
            h = $urandom_range(6);
         end
         k = ($urandom_range(4) == 0) ? $urandom_range(7) : 3 + 2 * $urandom_range(1);
         set_geometry(w, h, k, $urandom);
         repeat ($urandom_range(6)) add_coef();
         stream_frame();
         settle();
         phase++;
      end

      settle();
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
